// File: hw/rtl/dfnd_pkg.sv
// Shared widths, constants and pipeline stage types for the dipole field
// normal dot block. No dependencies.
`default_nettype none
package dfnd_pkg;
  localparam int SW   = 68;          // padded sum of squares
  localparam int RW   = 34;          // integer square root
  localparam int RMW  = RW + 3;      // sqrt partial remainder
  localparam int NSQ  = SW / 2;      // sqrt digit steps
  localparam int NUD  = 15;          // unit vector quotient bits
  localparam int UNW  = 49;          // unit vector dividend
  localparam int NDV  = 79;          // quotient bits per divide-by-r pass
  localparam int NQD  = 3 * NDV;     // three passes by r
  localparam logic [15:0] COEF_RST = 16'd12288;

  typedef logic [2:0][15:0] nvec_t;
  typedef logic [2:0][32:0] dvec_t;
  typedef logic [2:0][14:0] uvec_t;

  typedef struct packed {
    logic vld; dvec_t d; nvec_t ns; nvec_t nt;
  } f0_t;
  typedef struct packed {
    logic vld; dvec_t dm; logic [2:0] dneg; nvec_t ns; nvec_t nt;
  } f1_t;
  typedef struct packed {
    logic vld; logic [2:0][64:0] sq; dvec_t dm; logic [2:0] dneg; nvec_t ns; nvec_t nt;
  } f2_t;
  typedef struct packed {
    logic vld; logic [SW-1:0] s; logic [RMW-1:0] rem; logic [RW-1:0] root;
    dvec_t dm; logic [2:0] dneg; nvec_t ns; nvec_t nt; logic zero;
  } sq_t;
  typedef struct packed {
    logic vld; logic [2:0][UNW-1:0] n; uvec_t q; logic [RW-1:0] r;
    logic [2:0] dneg; nvec_t ns; nvec_t nt; logic zero;
  } ud_t;
  typedef struct packed {
    logic vld; logic [2:0][31:0] pr; uvec_t um; logic [2:0] dneg; logic [RW-1:0] r;
    nvec_t ns; nvec_t nt; logic zero;
  } p1_t;
  typedef struct packed {
    logic vld; logic [33:0] p; uvec_t um; logic [2:0] dneg; logic [RW-1:0] r;
    nvec_t ns; nvec_t nt; logic zero;
  } p2_t;
  typedef struct packed {
    logic vld; logic [48:0] t; logic pneg; uvec_t um; logic [2:0] dneg;
    logic [RW-1:0] r; nvec_t ns; nvec_t nt; logic zero;
  } t_t;
  typedef struct packed {
    logic vld; logic [2:0][37:0] pm; logic [2:0] neg; logic [RW-1:0] r;
    nvec_t ns; nvec_t nt; logic zero;
  } pm_t;
  typedef struct packed {
    logic vld; logic [2:0][39:0] g; logic [RW-1:0] r; nvec_t nt; logic zero;
  } g_t;
  typedef struct packed {
    logic vld; logic [2:0][55:0] gm; logic [RW-1:0] r; logic zero;
  } gm_t;
  typedef struct packed {
    logic vld; logic [57:0] m; logic [RW-1:0] r; logic zero;
  } m_t;
  typedef struct packed {
    logic vld; logic [NDV-1:0] n; logic [RW-1:0] rem; logic [RW-1:0] r;
    logic mneg; logic zero;
  } dv_t;
endpackage
`default_nettype wire

// File: hw/rtl/dipole_field_normal_dot.sv
// Dipole field / normal interaction, fully pipelined fixed-point datapath.
// Depends on dfnd_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): one beat is one (source, target) pair,
//    positions Q16.16, normals Q1.14. Output channel (out_valid/out_ready):
//    one beat per input beat, in order: interaction Q16.16 plus the
//    saturated and zero_distance flags.
//  - cfg_wr_en/cfg_wr_data write the Q4.12 field coefficient; write it only
//    while nothing is in flight. Reset value is 3.0.
//  - Throughput: one beat per cycle unless the output stalls; 300 register
//    stages in all. The depth is set by the one-bit-per-stage square root
//    (34 stages), the unit-vector divide (15 stages) and three chained
//    divides by r for 1/r^3 (237 stages).
//  - Stall: the whole pipe advances together; when out_valid is high and
//    out_ready low every stage holds and in_ready drops, so no beat is lost
//    or repeated. in_ready follows out_ready combinationally through adv.
//  - Reset (rst_n low, synchronous) clears all valid bits and restores the
//    coefficient; the pipe takes beats in the first cycle after reset.
`default_nettype none
module dipole_field_normal_dot (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_src_x,
  input  wire logic [31:0] in_src_y,
  input  wire logic [31:0] in_src_z,
  input  wire logic [15:0] in_src_nx,
  input  wire logic [15:0] in_src_ny,
  input  wire logic [15:0] in_src_nz,
  input  wire logic [31:0] in_tgt_x,
  input  wire logic [31:0] in_tgt_y,
  input  wire logic [31:0] in_tgt_z,
  input  wire logic [15:0] in_tgt_nx,
  input  wire logic [15:0] in_tgt_ny,
  input  wire logic [15:0] in_tgt_nz,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_interaction,
  output logic             out_saturated,
  output logic             out_zero_distance
);

  logic [15:0] coef_r;
  logic        adv;      // whole pipe moves one stage
  logic        out_valid_r, out_sat_r, out_zd_r;
  logic [31:0] out_val_r;

  dfnd_pkg::f0_t f0_r, f0_nxt;
  dfnd_pkg::f1_t f1_r, f1_nxt;
  dfnd_pkg::f2_t f2_r, f2_nxt;
  dfnd_pkg::sq_t sq_r [dfnd_pkg::NSQ+1];
  dfnd_pkg::sq_t sq0_nxt;
  dfnd_pkg::ud_t ud_r [dfnd_pkg::NUD+1];
  dfnd_pkg::ud_t ud0_nxt;
  dfnd_pkg::p1_t p1_r, p1_nxt;
  dfnd_pkg::p2_t p2_r, p2_nxt;
  dfnd_pkg::t_t  t_r,  t_nxt;
  dfnd_pkg::pm_t pm_r, pm_nxt;
  dfnd_pkg::g_t  g_r,  g_nxt;
  dfnd_pkg::gm_t gm_r, gm_nxt;
  dfnd_pkg::m_t  m_r,  m_nxt;
  dfnd_pkg::dv_t dv_r [dfnd_pkg::NQD+1];
  dfnd_pkg::dv_t dv0_nxt;

  logic        out_sat_nxt;
  logic [31:0] out_val_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_interaction   = out_val_r;
  assign out_saturated     = out_sat_r;
  assign out_zero_distance = out_zd_r;

  // coefficient register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= dfnd_pkg::COEF_RST;
    end else if (cfg_wr_en) begin
      coef_r <= cfg_wr_data;
    end
  end

  // ---- front: difference, magnitude, squares ----
  always_comb begin
    f0_nxt.vld = in_valid;
    f0_nxt.d[0] = $signed({in_src_x[31], in_src_x}) - $signed({in_tgt_x[31], in_tgt_x});
    f0_nxt.d[1] = $signed({in_src_y[31], in_src_y}) - $signed({in_tgt_y[31], in_tgt_y});
    f0_nxt.d[2] = $signed({in_src_z[31], in_src_z}) - $signed({in_tgt_z[31], in_tgt_z});
    f0_nxt.ns = {in_src_nz, in_src_ny, in_src_nx};
    f0_nxt.nt = {in_tgt_nz, in_tgt_ny, in_tgt_nx};
  end

  always_comb begin
    f1_nxt.vld = f0_r.vld;
    f1_nxt.ns  = f0_r.ns;
    f1_nxt.nt  = f0_r.nt;
    for (int i = 0; i < 3; i++) begin
      f1_nxt.dneg[i] = f0_r.d[i][32];
      f1_nxt.dm[i]   = f0_r.d[i][32] ? 33'(-f0_r.d[i]) : f0_r.d[i];
    end
  end

  always_comb begin
    f2_nxt.vld  = f1_r.vld;
    f2_nxt.dm   = f1_r.dm;
    f2_nxt.dneg = f1_r.dneg;
    f2_nxt.ns   = f1_r.ns;
    f2_nxt.nt   = f1_r.nt;
    for (int i = 0; i < 3; i++) begin
      f2_nxt.sq[i] = 65'(f1_r.dm[i]) * 65'(f1_r.dm[i]);
    end
  end

  always_comb begin
    sq0_nxt.vld  = f2_r.vld;
    sq0_nxt.s    = dfnd_pkg::SW'(f2_r.sq[0]) + dfnd_pkg::SW'(f2_r.sq[1])
                 + dfnd_pkg::SW'(f2_r.sq[2]);
    sq0_nxt.zero = (sq0_nxt.s == '0);
    sq0_nxt.rem  = '0;
    sq0_nxt.root = '0;
    sq0_nxt.dm   = f2_r.dm;
    sq0_nxt.dneg = f2_r.dneg;
    sq0_nxt.ns   = f2_r.ns;
    sq0_nxt.nt   = f2_r.nt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_r.vld <= 1'b0;
      f1_r.vld <= 1'b0;
      f2_r.vld <= 1'b0;
      sq_r[0].vld <= 1'b0;
    end else if (adv) begin
      f0_r <= f0_nxt;
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      sq_r[0] <= sq0_nxt;
    end
  end

  // ---- square root: two bits of S per stage ----
  for (genvar k = 0; k < dfnd_pkg::NSQ; k++) begin : g_sqrt
    dfnd_pkg::sq_t       nxt;
    logic [dfnd_pkg::RMW-1:0] sh, tr;
    always_comb begin
      sh  = {sq_r[k].rem[dfnd_pkg::RMW-3:0], sq_r[k].s[dfnd_pkg::SW-1 -: 2]};
      tr  = {1'b0, sq_r[k].root, 2'b01};
      nxt = sq_r[k];
      nxt.s = {sq_r[k].s[dfnd_pkg::SW-3:0], 2'b00};
      if (sh >= tr) begin
        nxt.rem  = sh - tr;
        nxt.root = {sq_r[k].root[dfnd_pkg::RW-2:0], 1'b1};
      end else begin
        nxt.rem  = sh;
        nxt.root = {sq_r[k].root[dfnd_pkg::RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1].vld <= 1'b0;
      end else if (adv) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // ---- unit vector: u = round(|d|*2^14 / r), one quotient bit per stage ----
  always_comb begin
    ud0_nxt.vld  = sq_r[dfnd_pkg::NSQ].vld;
    ud0_nxt.r    = sq_r[dfnd_pkg::NSQ].root;
    ud0_nxt.q    = '0;
    ud0_nxt.dneg = sq_r[dfnd_pkg::NSQ].dneg;
    ud0_nxt.ns   = sq_r[dfnd_pkg::NSQ].ns;
    ud0_nxt.nt   = sq_r[dfnd_pkg::NSQ].nt;
    ud0_nxt.zero = sq_r[dfnd_pkg::NSQ].zero;
    for (int i = 0; i < 3; i++) begin
      ud0_nxt.n[i] = {dfnd_pkg::UNW'(sq_r[dfnd_pkg::NSQ].dm[i]) << 14}
                   + dfnd_pkg::UNW'(sq_r[dfnd_pkg::NSQ].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ud_r[0].vld <= 1'b0;
    end else if (adv) begin
      ud_r[0] <= ud0_nxt;
    end
  end

  for (genvar k = 0; k < dfnd_pkg::NUD; k++) begin : g_udiv
    localparam int B = dfnd_pkg::NUD - 1 - k;
    dfnd_pkg::ud_t            nxt;
    logic [dfnd_pkg::UNW-1:0] tr;
    always_comb begin
      tr  = dfnd_pkg::UNW'(ud_r[k].r) << B;
      nxt = ud_r[k];
      for (int i = 0; i < 3; i++) begin
        if (ud_r[k].n[i] >= tr) begin
          nxt.n[i]    = ud_r[k].n[i] - tr;
          nxt.q[i][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ud_r[k+1].vld <= 1'b0;
      end else if (adv) begin
        ud_r[k+1] <= nxt;
      end
    end
  end

  // ---- projection p = ns . u ----
  always_comb begin
    logic signed [15:0] us, nsv;
    logic signed [31:0] prod;
    p1_nxt.vld  = ud_r[dfnd_pkg::NUD].vld;
    p1_nxt.um   = ud_r[dfnd_pkg::NUD].q;
    p1_nxt.dneg = ud_r[dfnd_pkg::NUD].dneg;
    p1_nxt.r    = ud_r[dfnd_pkg::NUD].r;
    p1_nxt.ns   = ud_r[dfnd_pkg::NUD].ns;
    p1_nxt.nt   = ud_r[dfnd_pkg::NUD].nt;
    p1_nxt.zero = ud_r[dfnd_pkg::NUD].zero;
    for (int i = 0; i < 3; i++) begin
      us   = $signed({1'b0, ud_r[dfnd_pkg::NUD].q[i]});
      if (ud_r[dfnd_pkg::NUD].dneg[i]) us = -us;
      nsv  = $signed(ud_r[dfnd_pkg::NUD].ns[i]);
      prod = nsv * us;
      p1_nxt.pr[i] = prod;
    end
  end

  always_comb begin
    p2_nxt.vld  = p1_r.vld;
    p2_nxt.p    = 34'($signed(p1_r.pr[0])) + 34'($signed(p1_r.pr[1]))
                + 34'($signed(p1_r.pr[2]));
    p2_nxt.um   = p1_r.um;
    p2_nxt.dneg = p1_r.dneg;
    p2_nxt.r    = p1_r.r;
    p2_nxt.ns   = p1_r.ns;
    p2_nxt.nt   = p1_r.nt;
    p2_nxt.zero = p1_r.zero;
  end

  // ---- t = C * |p| ----
  always_comb begin
    logic [33:0] pabs;
    pabs = p2_r.p[33] ? 34'(-p2_r.p) : p2_r.p;
    t_nxt.vld  = p2_r.vld;
    t_nxt.t    = 49'(coef_r) * 49'(pabs[32:0]);
    t_nxt.pneg = p2_r.p[33];
    t_nxt.um   = p2_r.um;
    t_nxt.dneg = p2_r.dneg;
    t_nxt.r    = p2_r.r;
    t_nxt.ns   = p2_r.ns;
    t_nxt.nt   = p2_r.nt;
    t_nxt.zero = p2_r.zero;
  end

  // ---- radial term magnitudes: (t * |u_i|) >> 26 ----
  always_comb begin
    logic [63:0] prod;
    pm_nxt.vld  = t_r.vld;
    pm_nxt.r    = t_r.r;
    pm_nxt.ns   = t_r.ns;
    pm_nxt.nt   = t_r.nt;
    pm_nxt.zero = t_r.zero;
    for (int i = 0; i < 3; i++) begin
      prod = 64'(t_r.t) * 64'(t_r.um[i]);
      pm_nxt.pm[i]  = prod[63:26];
      pm_nxt.neg[i] = t_r.pneg ^ t_r.dneg[i];
    end
  end

  // ---- g_i = ns_i*2^14 - signed radial term ----
  always_comb begin
    logic signed [39:0] sp, nb;
    g_nxt.vld  = pm_r.vld;
    g_nxt.r    = pm_r.r;
    g_nxt.nt   = pm_r.nt;
    g_nxt.zero = pm_r.zero;
    for (int i = 0; i < 3; i++) begin
      sp = $signed({2'b00, pm_r.pm[i]});
      if (pm_r.neg[i]) sp = -sp;
      nb = 40'($signed(pm_r.ns[i])) <<< 14;
      g_nxt.g[i] = nb - sp;
    end
  end

  always_comb begin
    logic signed [55:0] prod;
    gm_nxt.vld  = g_r.vld;
    gm_nxt.r    = g_r.r;
    gm_nxt.zero = g_r.zero;
    for (int i = 0; i < 3; i++) begin
      prod = 56'($signed(g_r.g[i])) * 56'($signed(g_r.nt[i]));
      gm_nxt.gm[i] = prod;
    end
  end

  always_comb begin
    m_nxt.vld  = gm_r.vld;
    m_nxt.m    = 58'($signed(gm_r.gm[0])) + 58'($signed(gm_r.gm[1]))
               + 58'($signed(gm_r.gm[2]));
    m_nxt.r    = gm_r.r;
    m_nxt.zero = gm_r.zero;
  end

  always_comb begin
    logic [57:0] mabs;
    mabs = m_r.m[57] ? 58'(-m_r.m) : m_r.m;
    dv0_nxt.vld  = m_r.vld;
    dv0_nxt.n    = {mabs[56:0], 22'b0};
    dv0_nxt.rem  = '0;
    dv0_nxt.r    = m_r.r;
    dv0_nxt.mneg = m_r.m[57];
    dv0_nxt.zero = m_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.vld <= 1'b0;
      p2_r.vld <= 1'b0;
      t_r.vld  <= 1'b0;
      pm_r.vld <= 1'b0;
      g_r.vld  <= 1'b0;
      gm_r.vld <= 1'b0;
      m_r.vld  <= 1'b0;
      dv_r[0].vld <= 1'b0;
    end else if (adv) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      t_r  <= t_nxt;
      pm_r <= pm_nxt;
      g_r  <= g_nxt;
      gm_r <= gm_nxt;
      m_r  <= m_nxt;
      dv_r[0] <= dv0_nxt;
    end
  end

  // ---- |m|*2^22 / r / r / r: restoring divide, one bit per stage ----
  // Each pass shifts the dividend out the top and the quotient in at the
  // bottom; the remainder restarts at zero at each pass boundary.
  for (genvar j = 0; j < dfnd_pkg::NQD; j++) begin : g_cdiv
    dfnd_pkg::dv_t          nxt;
    logic [dfnd_pkg::RW-1:0] rin;
    logic [dfnd_pkg::RW:0]   sh;
    always_comb begin
      if ((j % dfnd_pkg::NDV) == 0) begin
        rin = '0;
      end else begin
        rin = dv_r[j].rem;
      end
      sh  = {rin, dv_r[j].n[dfnd_pkg::NDV-1]};
      nxt = dv_r[j];
      if (sh >= {1'b0, dv_r[j].r}) begin
        nxt.rem = dfnd_pkg::RW'(sh - {1'b0, dv_r[j].r});
        nxt.n   = {dv_r[j].n[dfnd_pkg::NDV-2:0], 1'b1};
      end else begin
        nxt.rem = sh[dfnd_pkg::RW-1:0];
        nxt.n   = {dv_r[j].n[dfnd_pkg::NDV-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1].vld <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= nxt;
      end
    end
  end

  // ---- saturate, sign, coincident points ----
  always_comb begin
    logic [dfnd_pkg::NDV-1:0] q, lim;
    logic [31:0]              mv;
    q   = dv_r[dfnd_pkg::NQD].n;
    lim = dv_r[dfnd_pkg::NQD].mneg ? dfnd_pkg::NDV'(33'h080000000)
                                   : dfnd_pkg::NDV'(33'h07FFFFFFF);
    out_sat_nxt = (q > lim);
    mv = out_sat_nxt ? lim[31:0] : q[31:0];
    out_val_nxt = dv_r[dfnd_pkg::NQD].mneg ? 32'(-mv) : mv;
    if (dv_r[dfnd_pkg::NQD].zero) begin
      out_sat_nxt = 1'b0;
      out_val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[dfnd_pkg::NQD].vld;
      out_val_r   <= out_val_nxt;
      out_sat_r   <= out_sat_nxt;
      out_zd_r    <= dv_r[dfnd_pkg::NQD].zero;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dfnd_chk.sv
// Port-level checker for dipole_field_normal_dot, attached by bind.
// Depends on the top level's ports only.
`default_nettype none
module dfnd_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_interaction,
  input wire logic        out_saturated,
  input wire logic        out_zero_distance
);

  // input side is stalled exactly when the output beat is stuck
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_distance |-> out_interaction == 32'd0 && !out_saturated)
    else $error("coincident points must give a clean zero");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_interaction == 32'h7FFFFFFF || out_interaction == 32'h80000000)
    else $error("saturated beat not at a limit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interaction))
    else $error("stalled output beat changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dipole_field_normal_dot dfnd_chk u_dfnd_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_interaction(out_interaction),
  .out_saturated(out_saturated), .out_zero_distance(out_zero_distance)
);
`default_nettype wire
